// ----- design/hb32_pkg.sv -----
// ----------------------------------------------------------------------------
// hb32_pkg
// Shared types and constants for the hex / base32 text decoder.
// ----------------------------------------------------------------------------
package hb32_pkg;

  // character classes decided by the front end
  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // base select codes
  localparam logic BASE_HEX = 1'b0;
  localparam logic BASE_B32 = 1'b1;

  // digit widths per base
  localparam int unsigned HEX_BITS = 4;
  localparam int unsigned B32_BITS = 5;

  // accumulator geometry: at most 7 bits are held between characters
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned HELD_W    = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned WIDE_W    = 12;
  localparam int unsigned SUM_W     = 4;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // one classified character
  typedef struct packed {
    kind_e      kind;
    logic [4:0] digit;
    logic [7:0] text_char;
    logic       last;
    logic       b32;
  } entry_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- design/hb32_front.sv -----
// ----------------------------------------------------------------------------
// hb32_front
// Holds the base select register and classifies each character into a
// digit value, a pad or an error before it enters the queue.
// ----------------------------------------------------------------------------
module hb32_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            text_char_i,
  input  logic                  end_of_block_i,
  input  hb32_pkg::fifo_status_t fifo_status_i,
  output logic                  in_ready_o,
  output logic                  push_o,
  output hb32_pkg::entry_t      push_entry_o
);

  import hb32_pkg::*;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] ChPad   = 8'h3d;

  logic base_q, base_d;
  logic [7:0] val8;
  kind_e      kind;

  // base select register
  always_comb begin
    base_d = base_q;
    if (cfg_valid_i) begin
      base_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_HEX;
    end else begin
      base_q <= base_d;
    end
  end

  // character classification
  always_comb begin
    val8 = 8'd0;
    kind = KIND_ERROR;
    if (base_q == BASE_B32) begin
      if (text_char_i inside {[ChUpA:ChUpZ]}) begin
        val8 = text_char_i - ChUpA;
        kind = KIND_DIGIT;
      end else if (text_char_i inside {[ChLoA:ChLoZ]}) begin
        val8 = text_char_i - ChLoA;
        kind = KIND_DIGIT;
      end else if (text_char_i inside {[ChTwo:ChSeven]}) begin
        val8 = text_char_i - ChTwo + 8'd26;
        kind = KIND_DIGIT;
      end else if (text_char_i == ChPad) begin
        kind = KIND_PAD;
      end
    end else begin
      if (text_char_i inside {[ChZero:ChNine]}) begin
        val8 = text_char_i - ChZero;
        kind = KIND_DIGIT;
      end else if (text_char_i inside {[ChLoA:ChLoF]}) begin
        val8 = text_char_i - ChLoA + 8'd10;
        kind = KIND_DIGIT;
      end else if (text_char_i inside {[ChUpA:ChUpF]}) begin
        val8 = text_char_i - ChUpA + 8'd10;
        kind = KIND_DIGIT;
      end
    end
  end

  // transfer into the queue
  assign in_ready_o             = !fifo_status_i.full;
  assign push_o                 = in_valid_i && !fifo_status_i.full;
  assign push_entry_o.kind      = kind;
  assign push_entry_o.digit     = val8[4:0];
  assign push_entry_o.text_char = text_char_i;
  assign push_entry_o.last      = end_of_block_i;
  assign push_entry_o.b32       = base_q;

endmodule

// ----- design/hb32_fifo.sv -----
// ----------------------------------------------------------------------------
// hb32_fifo
// Short queue of classified characters between the front and back.
// ----------------------------------------------------------------------------
module hb32_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hb32_pkg::entry_t       push_entry_i,
  input  logic                   pop_i,
  output hb32_pkg::entry_t       pop_entry_o,
  output hb32_pkg::fifo_status_t status_o
);

  import hb32_pkg::*;

  entry_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [PTR_W-1:0]    rptr_q, rptr_d;
  logic [FCNT_W-1:0]   cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

  assign pop_entry_o     = mem_q[rptr_q];
  assign status_o.full   = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign status_o.empty  = (cnt_q == '0);

  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != FCNT_W'(FIFO_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");

endmodule

// ----- design/hb32_back.sv -----
// ----------------------------------------------------------------------------
// hb32_back
// Appends digit bits to the accumulator, emits completed bytes and error
// results through a registered output stage.
// ----------------------------------------------------------------------------
module hb32_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  hb32_pkg::fifo_status_t fifo_status_i,
  input  hb32_pkg::entry_t       pop_entry_i,
  input  logic                   out_ready_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output logic [7:0]             data_byte_o,
  output logic                   status_o
);

  import hb32_pkg::*;

  logic [HELD_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        data_q, data_d;
  logic              status_q, status_d;

  logic [WIDE_W-1:0] wide;
  logic [WIDE_W-1:0] rest_mask;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  rest;
  logic              full_byte;

  assign pop_o = !fifo_status_i.empty && (!out_valid_q || out_ready_i);

  // shift the digit in and split off a byte
  always_comb begin
    if (pop_entry_i.b32) begin
      wide = (WIDE_W'(acc_q) << B32_BITS) | WIDE_W'(pop_entry_i.digit);
      sum  = SUM_W'(cnt_q) + SUM_W'(B32_BITS);
    end else begin
      wide = (WIDE_W'(acc_q) << HEX_BITS) | WIDE_W'(pop_entry_i.digit[3:0]);
      sum  = SUM_W'(cnt_q) + SUM_W'(HEX_BITS);
    end
    full_byte = (sum >= SUM_W'(BYTE_BITS));
    rest      = CNT_W'(sum - SUM_W'(BYTE_BITS));
    rest_mask = (WIDE_W'(1) << rest) - WIDE_W'(1);
  end

  // accumulator and output stage update
  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    data_d      = data_q;
    status_d    = status_q;
    if (pop_o) begin
      case (pop_entry_i.kind)
        KIND_DIGIT: begin
          if (full_byte) begin
            out_valid_d = 1'b1;
            data_d      = 8'(wide >> rest);
            status_d    = STATUS_OK;
            acc_d       = HELD_W'(wide & rest_mask);
            cnt_d       = rest;
          end else begin
            acc_d = HELD_W'(wide);
            cnt_d = CNT_W'(sum);
          end
        end
        KIND_ERROR: begin
          out_valid_d = 1'b1;
          data_d      = pop_entry_i.text_char;
          status_d    = STATUS_ERROR;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      if (pop_entry_i.last) begin
        acc_d = '0;
        cnt_d = '0;
      end
    end
    if (cfg_valid_i) begin
      acc_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign status_o    = status_q;

  // only the low held bits of the accumulator may be set
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> cnt_q) == '0)
    else $error("stale bits above held count");

  // an error character always produces a result
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && pop_entry_i.kind == KIND_ERROR) |=> (out_valid_q && status_q == STATUS_ERROR))
    else $error("error character lost");

endmodule

// ----- design/hex_base32_text_to_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// hex_base32_text_to_byte_decoder
// Decodes a stream of hex or base32 characters into bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (base select)
//  in      | in        | in_valid_i/in_ready_o | text_char_i, end_of_block_i
//  out     | out       | out_valid_o/out_ready_i | data_byte_o, status_o
//
//  one character per cycle while the queue is not full; a result is presented
//  from the output register after its character passes the two-entry queue
//  and the accumulator stage, and is held there until out_ready_i
//  reset clears the base select to hex and empties accumulator and queue
//  a stalled output holds its register while the queue keeps taking
//  characters until it is full
// ----------------------------------------------------------------------------
module hex_base32_text_to_byte_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_char_i,
  input  logic       end_of_block_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       status_o
);

  import hb32_pkg::*;

  fifo_status_t fifo_status;
  entry_t       push_entry;
  entry_t       pop_entry;
  logic         push;
  logic         pop;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // front end: register and classification
  hb32_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .text_char_i    (text_char_i),
    .end_of_block_i (end_of_block_i),
    .fifo_status_i  (fifo_status),
    .in_ready_o     (in_ready_o),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  // queue between the two sides
  hb32_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (fifo_status)
  );

  // back end: accumulator and output register
  hb32_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .fifo_status_i (fifo_status),
    .pop_entry_i   (pop_entry),
    .out_ready_i   (out_ready_i),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o)
  );

endmodule
